// File: rtl/adcss_pkg.sv
// Shared constants and types for the ADC sample statistics block.
// No dependencies; compiled first.
package adcss_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int WINDOW_DEPTH = 16;
  localparam int REF_BITS     = 13;
  localparam int MV_BITS      = 13;
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int COUNT_BITS   = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_BITS     = $clog2(WINDOW_DEPTH);
  localparam int PROD_BITS    = SAMPLE_BITS + REF_BITS;
  localparam int STEP_BITS    = $clog2(SUM_BITS);

  localparam logic [REF_BITS-1:0] REF_RESET = REF_BITS'(2680);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [REF_BITS-1:0]    ref_t;
  typedef logic [MV_BITS-1:0]     mv_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [PTR_BITS-1:0]    ptr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/adcss_sample_if.sv
// Request channel carrying one raw ADC sample.
// Depends on adcss_pkg.
interface adcss_sample_if;
  import adcss_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: rtl/adcss_result_if.sv
// Result channel: peaks, window average and millivolt value.
// Depends on adcss_pkg.
interface adcss_result_if;
  import adcss_pkg::*;

  logic    valid;
  logic    ready;
  sample_t max_reading;
  sample_t min_reading;
  sample_t window_average;
  mv_t     voltage_mv;

  modport source (output valid, output max_reading, output min_reading,
                  output window_average, output voltage_mv, input ready);
  modport sink (input valid, input max_reading, input min_reading,
                input window_average, input voltage_mv, output ready);
endinterface

// File: rtl/adcss_divider.sv
// Restoring divider, one quotient bit per cycle, with separate compare and subtract.
// Depends on adcss_pkg.
module adcss_divider (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  adcss_pkg::sum_t   dividend,
  input  adcss_pkg::count_t divisor,
  output logic             done,
  output adcss_pkg::sum_t   quotient
);
  import adcss_pkg::*;

  logic                  active;
  logic [STEP_BITS-1:0]  step;
  sum_t                  quo;
  count_t                rem;
  count_t                dvs;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  assign trial    = {rem, quo[SUM_BITS-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(SUM_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active) begin
      if (fits) begin
        rem <= COUNT_BITS'(trial - {1'b0, dvs});
        quo <= {quo[SUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[COUNT_BITS-1:0];
        quo <= {quo[SUM_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/adc_sample_statistics_top.sv
// ADC sample statistics: running peaks, 16-sample window average, millivolts.
// Depends on adcss_pkg, adcss_sample_if, adcss_result_if, adcss_divider.
//
// Each accepted sample yields one result: the largest and smallest sample since
// reset (the first sample seeds both), the truncated mean of the last 16 samples
// (of all samples until 16 have arrived), and sample * reference_millivolts / 4096
// truncated. The peaks, window sum and ring are updated, and the millivolt product
// registered, at the accepting edge. The bit-serial restoring divider then forms
// the average; its done moves the sequencer to the finish state, which loads the
// output register once that register is empty or being read, and then returns to
// idle, where the next sample can be taken. The block takes no sample while an item
// is in progress; a new sample is taken while a finished result still waits in the
// output register. The reference register is written through cfg_write/cfg_data;
// the user must write it only while idle, which the block does not enforce.
module adc_sample_statistics_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  adcss_pkg::ref_t         cfg_data,
  adcss_sample_if.sink           sample_in,
  adcss_result_if.source         result_out
);
  import adcss_pkg::*;

  state_t  state;
  state_t  state_next;
  logic    in_ready;
  logic    load_result;
  logic    accept;

  ref_t    reference_mv;
  sample_t ring [WINDOW_DEPTH];
  sum_t    window_sum;
  sum_t    window_sum_next;
  count_t  sample_count;
  count_t  sample_count_next;
  ptr_t    ring_pointer;
  sample_t peak_high;
  sample_t peak_low;
  mv_t     voltage;
  logic    window_full;

  logic [PROD_BITS-1:0] product;

  logic    div_done;
  sum_t    quotient;

  logic    result_valid;
  sample_t res_max;
  sample_t res_min;
  sample_t res_avg;
  mv_t     res_mv;

  assign accept      = sample_in.valid && in_ready;
  assign window_full = sample_count == COUNT_BITS'(WINDOW_DEPTH);
  assign product     = PROD_BITS'(sample_in.sample) * PROD_BITS'(reference_mv);

  always_comb begin
    if (window_full) begin
      window_sum_next   = window_sum - SUM_BITS'(ring[ring_pointer])
                          + SUM_BITS'(sample_in.sample);
      sample_count_next = sample_count;
    end else begin
      window_sum_next   = window_sum + SUM_BITS'(sample_in.sample);
      sample_count_next = sample_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    load_result = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (sample_in.valid) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!result_valid || result_out.ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mv <= REF_RESET;
      window_sum   <= '0;
      sample_count <= '0;
      ring_pointer <= '0;
      peak_high    <= '0;
      peak_low     <= '0;
    end else begin
      if (cfg_write) reference_mv <= cfg_data;
      if (accept) begin
        window_sum   <= window_sum_next;
        sample_count <= sample_count_next;
        ring_pointer <= (ring_pointer == PTR_BITS'(WINDOW_DEPTH - 1)) ? '0
                        : ring_pointer + 1'b1;
        if (sample_count == '0) begin
          peak_high <= sample_in.sample;
          peak_low  <= sample_in.sample;
        end else begin
          if (sample_in.sample > peak_high) peak_high <= sample_in.sample;
          if (sample_in.sample < peak_low) peak_low <= sample_in.sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[ring_pointer] <= sample_in.sample;
      voltage            <= product[PROD_BITS-1:SAMPLE_BITS];
    end
  end

  adcss_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (window_sum_next),
    .divisor  (sample_count_next),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_out.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      res_max <= peak_high;
      res_min <= peak_low;
      res_avg <= quotient[SAMPLE_BITS-1:0];
      res_mv  <= voltage;
    end
  end

  assign sample_in.ready           = in_ready;
  assign result_out.valid          = result_valid;
  assign result_out.max_reading    = res_max;
  assign result_out.min_reading    = res_min;
  assign result_out.window_average = res_avg;
  assign result_out.voltage_mv     = res_mv;

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample_in.ready)
    else $error("sample taken while an item was in progress");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= COUNT_BITS'(WINDOW_DEPTH))
    else $error("sample count past window depth");

  a_result_order: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.min_reading <= result_out.window_average)
                         && (result_out.window_average <= result_out.max_reading))
    else $error("average outside peak range");

endmodule

// File: tb/adc_sample_statistics_top_tb.sv
// Testbench for adc_sample_statistics_top: peaks, 16-sample window average, millivolts.
// Uses adcss_pkg, adcss_sample_if, adcss_result_if; a cycle-free predictor checks every result
// under random request gaps and result stalls across several reference settings.
module adc_sample_statistics_top_tb;
  import adcss_pkg::*;

  typedef struct packed {
    sample_t max_reading;
    sample_t min_reading;
    sample_t window_average;
    mv_t     voltage_mv;
  } stats_t;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 40;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_write = 1'b0;
  ref_t    cfg_data = '0;
  logic    sample_valid = 1'b0;
  sample_t sample_value = '0;
  logic    result_ready = 1'b0;

  adcss_sample_if sample_bus ();
  adcss_result_if result_bus ();

  assign sample_bus.valid  = sample_valid;
  assign sample_bus.sample = sample_value;
  assign result_bus.ready  = result_ready;

  adc_sample_statistics_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .sample_in (sample_bus),
    .result_out(result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, matches the block after reset
  sample_t ring [WINDOW_DEPTH];
  sum_t    window_sum = '0;
  count_t  held = '0;
  ptr_t    next_slot = '0;
  sample_t peak_high = '0;
  sample_t peak_low = '0;
  ref_t    ref_setting = REF_RESET;

  sample_t pending_samples [$];
  stats_t  expected_stats [$];
  stats_t  oldest_stats;

  int  errors = 0;
  int  samples_sent = 0;
  int  results_checked = 0;
  int  settings_used = 1;
  int  quiet_cycles = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  function automatic stats_t next_stats(sample_t s);
    stats_t r;
    logic [PROD_BITS-1:0] product;
    if (held == 0) begin
      peak_high = s;
      peak_low = s;
    end else begin
      if (s > peak_high) peak_high = s;
      if (s < peak_low) peak_low = s;
    end
    if (held == count_t'(WINDOW_DEPTH)) window_sum = window_sum - ring[next_slot];
    else held = held + 1'b1;
    window_sum = window_sum + s;
    ring[next_slot] = s;
    next_slot = next_slot + 1'b1;
    product = PROD_BITS'(s) * PROD_BITS'(ref_setting);
    r.max_reading = peak_high;
    r.min_reading = peak_low;
    r.window_average = sample_t'(window_sum / held);
    r.voltage_mv = mv_t'(product >> SAMPLE_BITS);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 60);
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return sample_t'($urandom_range(0, 15));
      3: return sample_t'($urandom_range(4080, 4095));
      default: return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_bus.ready) begin
        expected_stats.push_back(next_stats(sample_value));
        samples_sent++;
      end
      if (!sample_valid || sample_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_valid <= 1'b1;
          sample_value <= pending_samples.pop_front();
          send_gap = idle_on ? pick_gap() : 0;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_ready) begin
        results_checked++;
        if (expected_stats.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          oldest_stats = expected_stats.pop_front();
          check_field("max_reading", result_bus.max_reading, oldest_stats.max_reading);
          check_field("min_reading", result_bus.min_reading, oldest_stats.min_reading);
          check_field("window_average", result_bus.window_average,
                      oldest_stats.window_average);
          check_field("voltage_mv", result_bus.voltage_mv, oldest_stats.voltage_mv);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
      if ((sample_valid && sample_bus.ready) || (result_bus.valid && result_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
    $display("adc_sample_statistics_top verification failed");
    $finish;
  end

  task automatic wait_idle();
    while (pending_samples.size() != 0 || sample_valid || expected_stats.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(ref_t setting, int count, bit idle);
    wait_idle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= setting;
    ref_setting = setting;
    settings_used++;
    @(posedge clk);
    cfg_write <= 1'b0;
    idle_on = idle;
    repeat (count) pending_samples.push_back(random_sample());
  endtask

  initial begin
    sample_t directed [20] = '{12'd2048, 12'd4095, 12'd0, 12'hAAA, 12'h555, 12'd1,
                               12'd4094, 12'd7, 12'd4088, 12'd100, 12'd3000, 12'd0,
                               12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd2, 12'd3,
                               12'd1000, 12'd4095};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // first sample seeds both peaks; window fills past 16 to force eviction
    foreach (directed[i]) pending_samples.push_back(directed[i]);

    run_phase(ref_t'(5000), 280, 1'b1);
    run_phase(ref_t'(0), 200, 1'b0);
    run_phase('1, 280, 1'b1);
    run_phase(ref_t'(1), 200, 1'b1);
    run_phase(ref_t'(4096), 280, 1'b0);
    run_phase(ref_t'($urandom_range(0, 8191)), 360, 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_stats.size() != 0)
      report($sformatf("%0d results never arrived", expected_stats.size()));

    $display("covered %0d samples and %0d results over %0d reference settings",
             samples_sent, results_checked, settings_used);
    $display("reference settings included 0, 1, 4096, 5000 and 8191; %0d mismatches", errors);
    if (errors == 0)
      $display("adc_sample_statistics_top verification clean");
    else
      $display("adc_sample_statistics_top verification failed");
    $finish;
  end

endmodule
